// ----- design/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- design/kfifo_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package kfifo_pkg;
  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] KIND_ENQ = 3'd0;
  localparam logic [2:0] KIND_DEQ = 3'd1;
  localparam logic [2:0] KIND_PEEK = 3'd2;
  localparam logic [2:0] KIND_SEARCH = 3'd3;
  localparam logic [2:0] KIND_DEL = 3'd4;
  localparam logic [2:0] KIND_UPD = 3'd5;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic [2:0] kind;
    logic [63:0] record_key;
    logic [63:0] holder_name;
    logic [63:0] phone_digits;
    logic [7:0] licence_class;
    logic [7:0] sex_code;
    logic [63:0] address_text;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [63:0] out_key;
    logic [63:0] out_name;
    logic [63:0] out_phone;
    logic [7:0] out_class;
    logic [7:0] out_sex;
    logic [63:0] out_address;
    logic [4:0] entry_total;
  } out_word_t;

  typedef struct packed {
    logic [63:0] key;
    logic [63:0] name;
    logic [63:0] phone;
    logic [7:0] lclass;
    logic [7:0] sex;
    logic [63:0] address;
  } rec_t;

  typedef struct packed {
    logic we;
    logic [IDX_W-1:0] waddr;
    rec_t wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;
endpackage
`default_nettype wire

// ----- design/kfifo_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module kfifo_ram (
  input  wire logic clk,
  input  wire kfifo_pkg::mem_req_t req,
  output kfifo_pkg::rec_t rdata
);
  kfifo_pkg::rec_t mem [kfifo_pkg::QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end
endmodule
`default_nettype wire

// ----- design/kfifo_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module kfifo_ctrl (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire kfifo_pkg::in_word_t in_data,
  output logic out_valid,
  input  wire logic out_ready,
  output kfifo_pkg::out_word_t out_data,
  output kfifo_pkg::mem_req_t req,
  input  wire kfifo_pkg::rec_t rdata,
  output logic [kfifo_pkg::CNT_W-1:0] count
);
  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_SHIFT, S_DONE} state_t;
  localparam int IW = kfifo_pkg::IDX_W;
  localparam int CW = kfifo_pkg::CNT_W;

  state_t state_r;
  kfifo_pkg::in_word_t cmd_r;
  logic [CW-1:0] cnt_r, idx_r;
  logic [CW-1:0] prev_r;
  logic rd_pend_r;
  kfifo_pkg::rec_t hit_r;
  logic [1:0] st_r;
  logic has_rec_r;
  logic out_full_r;
  kfifo_pkg::out_word_t out_r;

  kfifo_pkg::rec_t in_rec;
  logic [CW-1:0] idx_inc;
  logic [CW-1:0] cnt_dec;
  logic scan_hit;

  assign in_rec = '{key: cmd_r.record_key, name: cmd_r.holder_name,
                    phone: cmd_r.phone_digits, lclass: cmd_r.licence_class,
                    sex: cmd_r.sex_code, address: cmd_r.address_text};
  assign idx_inc = idx_r + CW'(1);
  assign cnt_dec = cnt_r - CW'(1);
  assign scan_hit = rd_pend_r && (rdata.key == cmd_r.record_key
                    || cmd_r.kind == kfifo_pkg::KIND_DEQ
                    || cmd_r.kind == kfifo_pkg::KIND_PEEK);
  assign in_ready = (state_r == S_IDLE) && !out_full_r;
  assign out_valid = out_full_r;
  assign out_data = out_r;
  assign count = cnt_r;

  // prev_r addresses rdata in S_SCAN, its write slot in S_SHIFT
  always_comb begin
    req = '0;
    req.raddr = idx_r[IW-1:0];
    case (state_r)
      S_SCAN: begin
        if (scan_hit && cmd_r.kind == kfifo_pkg::KIND_UPD) begin
          req.we = 1'b1;
          req.waddr = prev_r[IW-1:0];
          req.wdata = in_rec;
        end
      end
      S_SHIFT: begin
        req.raddr = idx_inc[IW-1:0];
        if (rd_pend_r) begin
          req.we = 1'b1;
          req.waddr = prev_r[IW-1:0];
          req.wdata = rdata;
        end
      end
      S_DONE: begin
        if (cmd_r.kind == kfifo_pkg::KIND_ENQ && st_r == kfifo_pkg::ST_OK) begin
          req.we = 1'b1;
          req.waddr = cnt_r[IW-1:0];
          req.wdata = in_rec;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      out_full_r <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      if (out_full_r && out_ready) out_full_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            cmd_r <= in_data;
            idx_r <= '0;
            rd_pend_r <= 1'b0;
            has_rec_r <= 1'b0;
            st_r <= kfifo_pkg::ST_OK;
            case (in_data.kind)
              kfifo_pkg::KIND_ENQ: begin
                if (cnt_r == CW'(kfifo_pkg::QUEUE_DEPTH)) st_r <= kfifo_pkg::ST_FULL;
                state_r <= S_DONE;
              end
              kfifo_pkg::KIND_DEQ, kfifo_pkg::KIND_PEEK, kfifo_pkg::KIND_DEL: begin
                if (cnt_r == '0) begin
                  st_r <= kfifo_pkg::ST_EMPTY;
                  state_r <= S_DONE;
                end else begin
                  state_r <= S_SCAN;
                end
              end
              kfifo_pkg::KIND_SEARCH, kfifo_pkg::KIND_UPD: begin
                if (cnt_r == '0) begin
                  st_r <= kfifo_pkg::ST_NOTFOUND;
                  state_r <= S_DONE;
                end else begin
                  state_r <= S_SCAN;
                end
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_SCAN: begin
          prev_r <= idx_r;
          if (scan_hit) begin
            hit_r <= rdata;
            has_rec_r <= 1'b1;
            if (cmd_r.kind == kfifo_pkg::KIND_DEQ || cmd_r.kind == kfifo_pkg::KIND_DEL) begin
              idx_r <= prev_r;
              rd_pend_r <= 1'b0;
              state_r <= S_SHIFT;
            end else begin
              state_r <= S_DONE;
            end
          end else if (rd_pend_r && prev_r == cnt_dec) begin
            st_r <= kfifo_pkg::ST_NOTFOUND;
            state_r <= S_DONE;
          end else begin
            rd_pend_r <= 1'b1;
            idx_r <= idx_inc;
          end
        end
        S_SHIFT: begin
          prev_r <= idx_r;
          if (idx_inc >= cnt_r) begin
            cnt_r <= cnt_dec;
            state_r <= S_DONE;
          end else begin
            rd_pend_r <= 1'b1;
            idx_r <= idx_inc;
          end
        end
        S_DONE: begin
          if (cmd_r.kind == kfifo_pkg::KIND_ENQ && st_r == kfifo_pkg::ST_OK)
            cnt_r <= cnt_r + CW'(1);
          out_r.status <= st_r;
          out_r.out_key <= has_rec_r ? hit_r.key : '0;
          out_r.out_name <= has_rec_r ? hit_r.name : '0;
          out_r.out_phone <= has_rec_r ? hit_r.phone : '0;
          out_r.out_class <= has_rec_r ? hit_r.lclass : '0;
          out_r.out_sex <= has_rec_r ? hit_r.sex : '0;
          out_r.out_address <= has_rec_r ? hit_r.address : '0;
          out_r.entry_total <= 5'((cmd_r.kind == kfifo_pkg::KIND_ENQ
                               && st_r == kfifo_pkg::ST_OK) ? cnt_r + CW'(1) : cnt_r);
          out_full_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- design/keyed_fifo_with_delete_by_key.sv -----
// enqueue, empty-queue results and unused kinds: S_IDLE goes straight to S_DONE
// search, update and peek: S_SCAN reads held records until one matches or all are read
// dequeue and delete: S_SCAN finds the record, S_SHIFT moves each later record down a slot
// one word at a time; next word taken the cycle after the result leaves
// reset: synchronous active-low rst_n empties the queue, record memory is not cleared
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module keyed_fifo_with_delete_by_key (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire kfifo_pkg::in_word_t in_data,
  output logic out_valid,
  input  wire logic out_ready,
  output kfifo_pkg::out_word_t out_data
);
  kfifo_pkg::mem_req_t req;
  kfifo_pkg::rec_t rdata;
  logic [kfifo_pkg::CNT_W-1:0] count;

  kfifo_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data, .req, .rdata, .count
  );
  kfifo_ram u_ram (.clk, .req, .rdata);

  `ASSERT_IMPL(a_cnt_max, clk, rst_n, 1'b1, count <= kfifo_pkg::CNT_W'(kfifo_pkg::QUEUE_DEPTH))
  `ASSERT_IMPL(a_busy, clk, rst_n, out_valid, !in_ready)
  `ASSERT_NEXT(a_cnt_hold, clk, rst_n, in_ready && !in_valid, $stable(count))
endmodule
`default_nettype wire
